// ===== rtl/core/acfd_pkg.sv =====
`default_nettype none
package acfd_pkg;

    localparam int FrameMaxDef = 35;
    localparam int StoreDepth  = 17;
    localparam int MinLen      = 3;

    localparam logic [7:0] StartDef = 8'h53;  // 'S'
    localparam logic [7:0] EndDef   = 8'h23;  // '#'
    localparam logic [7:0] ChP      = 8'h50;
    localparam logic [7:0] ChO      = 8'h4F;
    localparam logic [7:0] ChT      = 8'h54;
    localparam logic [7:0] ChF      = 8'h46;
    localparam logic [7:0] ChL      = 8'h4C;
    localparam logic [7:0] Ch0      = 8'h30;
    localparam logic [7:0] Ch1      = 8'h31;
    localparam logic [7:0] Ch5      = 8'h35;
    localparam logic [7:0] Ch9      = 8'h39;

    localparam logic [2:0] Led1Rst  = 3'd2;
    localparam logic [2:0] LedBad   = 3'd5;
    localparam logic [2:0] LedOk    = 3'd0;
    localparam logic [7:0] SecsBad  = 8'd120;

    typedef enum logic [0:0] {
        CfgStart = 1'b0,
        CfgEnd   = 1'b1
    } t_cfg_idx;

    typedef logic [7:0] t_byte;
    typedef logic [StoreDepth-1:0][7:0] t_frame;

    typedef struct packed {
        logic [2:0] led1;
        logic [2:0] led2;
        logic [2:0] led3;
        logic [7:0] sw_bits;
    } t_ctrl;

    typedef struct packed {
        t_ctrl      ctrl;
        logic       tmr_valid;
        logic       tmr_device;
        logic       tmr_open;
        logic [7:0] tmr_secs;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/acfd_decode.sv =====
`default_nettype none
module acfd_decode (
    input  wire acfd_pkg::t_frame  i_frame,
    input  wire                    i_len_ok,
    input  wire acfd_pkg::t_byte   i_start_char,
    input  wire acfd_pkg::t_ctrl   i_ctrl,
    output acfd_pkg::t_result      o_result
);
    import acfd_pkg::*;

    function automatic logic [2:0] mode_upd(input logic [2:0] cur, input t_byte c);
        t_byte diff;
        diff = c - Ch0;
        if (c >= Ch0 && c <= Ch5) begin
            return diff[2:0];
        end
        return cur;
    endfunction

    t_byte      tens;
    t_byte      ones;
    logic [7:0] secs_calc;
    logic       bad_digit;
    logic [2:0] tmr_mode;

    // seconds = tens*10 + ones, all mod 256
    assign tens      = i_frame[10] - Ch0;
    assign ones      = i_frame[11] - Ch0;
    assign secs_calc = {tens[4:0], 3'b000} + {tens[6:0], 1'b0} + ones;
    assign bad_digit = (i_frame[10] > Ch9) || (i_frame[11] > Ch9);
    assign tmr_mode  = bad_digit ? LedBad : LedOk;

    always_comb begin
        o_result      = '0;
        o_result.ctrl = i_ctrl;
        if (i_len_ok && i_frame[0] == i_start_char) begin
            if (i_frame[4] == ChP) begin
                o_result.ctrl.led1 = mode_upd(i_ctrl.led1, i_frame[5]);
                o_result.ctrl.led2 = mode_upd(i_ctrl.led2, i_frame[6]);
                o_result.ctrl.led3 = mode_upd(i_ctrl.led3, i_frame[7]);
                for (int k = 0; k < 8; k++) begin
                    if (i_frame[9+k] == Ch0) begin
                        o_result.ctrl.sw_bits[k] = 1'b0;
                    end else if (i_frame[9+k] == Ch1) begin
                        o_result.ctrl.sw_bits[k] = 1'b1;
                    end
                end
            end
            if (i_frame[2] == ChO && i_frame[5] == ChT &&
                (i_frame[3] == ChF || i_frame[3] == ChL)) begin
                o_result.tmr_valid  = 1'b1;
                o_result.tmr_device = (i_frame[3] == ChL);
                o_result.tmr_open   = (i_frame[4] != Ch0);
                o_result.tmr_secs   = bad_digit ? SecsBad : secs_calc;
                if (i_frame[3] == ChL) begin
                    o_result.ctrl.led3 = tmr_mode;
                end else begin
                    o_result.ctrl.led2 = tmr_mode;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/acfd_obuf.sv =====
`default_nettype none
module acfd_obuf (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire acfd_pkg::t_result i_data,
    output logic                 o_room,
    output logic                 o_valid,
    output acfd_pkg::t_result    o_data,
    input  wire                  i_ready
);
    import acfd_pkg::*;

    logic    r_out_valid;
    logic    r_skd_valid;
    t_result r_out;
    t_result r_skd;
    logic    pop;

    assign pop     = r_out_valid & i_ready;
    assign o_room  = ~r_skd_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // skid word only fills while the head word is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (pop) begin
                r_out       <= r_skd;
                r_skd_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out       <= i_data;
                r_out_valid <= 1'b1;
            end else begin
                r_skd       <= i_data;
                r_skd_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ascii_command_frame_decoder.sv =====
// A result word is on the output in the cycle after its closing byte is accepted
// when the head word is free, or later if it waits in the skid word behind a stalled word.
// Throughput: one byte per cycle. Frame tracking and decode sit between the byte
// input and a two-word output buffer, so bytes keep flowing while one result stalls.
// Input stalls only when both output words are held.
// Reset (sync, active low): chars 'S'/'#', store zero, LEDs 2/0/0, switches 0, buffer empty.
`default_nettype none
module ascii_command_frame_decoder #(
    parameter int FRAME_MAX = acfd_pkg::FrameMaxDef
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // configuration write channel
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [0:0]  i_cfg_index,
    input  wire [7:0]  i_cfg_data,
    // byte input
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire [7:0]  i_rx_byte,
    // result output
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [2:0] o_led1_mode,
    output logic [2:0] o_led2_mode,
    output logic [2:0] o_led3_mode,
    output logic [7:0] o_switch_bits,
    output logic       o_timer_valid,
    output logic       o_timer_device,
    output logic       o_timer_open,
    output logic [7:0] o_timer_seconds
);
    import acfd_pkg::*;

    // byte counter must hold FRAME_MAX itself
    localparam int CntW = $clog2(FRAME_MAX + 1);

    // configuration
    t_byte r_start;
    t_byte r_end;

    // frame tracking
    logic            r_in_frame;
    logic [CntW-1:0] r_count;
    t_frame          r_store;
    t_ctrl           r_ctrl;

    logic            acc;
    logic            is_start;
    logic            live;       // byte belongs to a frame
    logic [CntW-1:0] cnt;        // count seen by this byte
    logic            room;       // frame still below FRAME_MAX
    logic            close;
    logic [CntW-1:0] n_count;
    logic            n_in_frame;
    t_frame          n_store;
    logic            len_ok;
    t_result         result;
    t_result         out_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= StartDef;
            r_end   <= EndDef;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CfgStart: r_start <= i_cfg_data;
                CfgEnd:   r_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign acc      = i_in_valid & o_in_ready;
    // start byte reopens a frame anywhere, even mid-frame
    assign is_start = (i_rx_byte == r_start);
    assign live     = r_in_frame | is_start;
    assign cnt      = is_start ? '0 : r_count;
    assign room     = (cnt < CntW'(FRAME_MAX));
    // overflow byte closes the frame without being stored or counted
    assign close    = live & (room ? (i_rx_byte == r_end) : 1'b1);
    assign n_count  = room ? (cnt + 1'b1) : cnt;
    assign n_in_frame = live & ~close;
    assign len_ok   = (n_count >= CntW'(MinLen));

    // store write; positions past the store are counted only.
    // Untouched positions keep bytes from older frames on purpose.
    always_comb begin
        for (int k = 0; k < StoreDepth; k++) begin
            if (live && room && cnt == CntW'(k)) begin
                n_store[k] = i_rx_byte;
            end else begin
                n_store[k] = r_store[k];
            end
        end
    end

    // decode sees the store including the closing byte, if it is stored
    acfd_decode u_decode (
        .i_frame      (n_store),
        .i_len_ok     (len_ok),
        .i_start_char (r_start),
        .i_ctrl       (r_ctrl),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_store    <= '0;
            r_ctrl     <= '{led1: Led1Rst, led2: 3'd0, led3: 3'd0, sw_bits: 8'd0};
        end else if (acc && live) begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_store    <= n_store;
            if (close) begin
                r_ctrl <= result.ctrl;
            end
        end
    end

    acfd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc & close),
        .i_data  (result),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .o_data  (out_word),
        .i_ready (i_out_ready)
    );

    assign o_led1_mode     = out_word.ctrl.led1;
    assign o_led2_mode     = out_word.ctrl.led2;
    assign o_led3_mode     = out_word.ctrl.led3;
    assign o_switch_bits   = out_word.ctrl.sw_bits;
    assign o_timer_valid   = out_word.tmr_valid;
    assign o_timer_device  = out_word.tmr_device;
    assign o_timer_open    = out_word.tmr_open;
    assign o_timer_seconds = out_word.tmr_secs;

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // a closing byte always leaves the frame closed
    a_close_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && close) |=> !r_in_frame)
        else $error("frame still open after close");

    // output is valid in the cycle after a closing byte is accepted
    a_close_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && close) |=> o_out_valid)
        else $error("closed frame produced no result");

    // timer fields are zero unless a timer command was decoded
    a_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_timer_valid) |->
            (!o_timer_device && !o_timer_open && o_timer_seconds == 8'd0))
        else $error("timer fields set without timer command");

endmodule
`default_nettype wire
